// ===== rtl/contiguous_frame_allocator_unit_defines.svh =====
// Assertion macros for the contiguous frame allocator
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define CFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CFA_ASSERT_SAME(lbl, ante, cons, msg)
`define CFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/cfa_pkg.sv =====
// Shared types and constants of the contiguous frame allocator
`default_nettype none
package cfa_pkg;
  localparam int unsigned MAX_FRAMES      = 1024;
  localparam int unsigned FRAMES_PER_WORD = 4;
  localparam int unsigned WORD_DEPTH      = MAX_FRAMES / FRAMES_PER_WORD;
  localparam int unsigned FIDX_W          = $clog2(MAX_FRAMES);
  localparam int unsigned CNT_W           = FIDX_W + 1;
  localparam int unsigned WADDR_W         = $clog2(WORD_DEPTH);
  localparam int unsigned WORD_W          = 2 * FRAMES_PER_WORD;

  typedef enum logic [1:0] {
    FS_FREE  = 2'd0,
    FS_INFO  = 2'd1,
    FS_HEAD  = 2'd2,
    FS_ALLOC = 2'd3
  } frame_state_e;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_MARK    = 2'd2,
    FN_INIT    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NORUN   = 2'd1,
    STS_NOTHEAD = 2'd2,
    STS_RANGE   = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SRCH  = 7'b0000100,
    S_MRD   = 7'b0001000,
    S_MWR   = 7'b0010000,
    S_RRD   = 7'b0100000,
    S_RWR   = 7'b1000000
  } fsm_e;

  localparam logic [0:0] CFG_FRAMES_IN_USE = 1'b0;
  localparam logic [0:0] CFG_INFO_IN_POOL  = 1'b1;
endpackage
`default_nettype wire

// ===== rtl/contiguous_frame_allocator_unit.sv =====
// Allocate searches the pool at four frames per word, then does a read-modify-write per word of the run;
// release and mark do a read-modify-write per word touched; init sweeps all 256 words.
// Range errors answer in the cycle after the start transfer. One item at a time, busy high meanwhile.
// The state RAM port (one word of four frames per cycle) sets the pace of each operation.
// Reset clears the pool in a sweep over all 256 words with busy high; results cannot be stalled.
`default_nettype none
`include "contiguous_frame_allocator_unit_defines.svh"
module contiguous_frame_allocator_unit
  import cfa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        func_i,
  input  wire logic [FIDX_W-1:0] frame_index_i,
  input  wire logic [CNT_W-1:0]  frame_count_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [0:0]        cfg_index_i,
  input  wire logic [CNT_W-1:0]  cfg_data_i,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [FIDX_W-1:0]      first_frame_o,
  output logic [CNT_W-1:0]       free_frames_o
);
  fsm_e                state_q, state_d;
  logic [CNT_W-1:0]    fiu_q;
  logic                info_cfg_q;
  logic [CNT_W-1:0]    pool_q, pool_d;
  logic                info_lat_q, info_lat_d;
  logic [CNT_W-1:0]    free_q, free_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [WADDR_W-1:0]  addr_q, addr_d;
  logic [WADDR_W-1:0]  dw_q, dw_d;
  logic                rd_pend_q, rd_pend_d;
  logic [CNT_W-1:0]    run_q, run_d;
  logic [FIDX_W-1:0]   head_q, head_d;
  logic [FIDX_W-1:0]   last_q, last_d;
  logic                first_q, first_d;
  logic                clr_init_q, clr_init_d;
  logic                done_q, done_d;
  logic [1:0]          status_q, status_d;
  logic [FIDX_W-1:0]   ffr_q, ffr_d;

  logic                we;
  logic [WORD_W-1:0]   wdata;
  logic [WORD_W-1:0]   rdata;
  logic                accept;

  cfa_frame_ram #(.DEPTH(WORD_DEPTH), .WIDTH(WORD_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign busy          = (state_q != S_IDLE);
  assign accept        = start && !busy;
  assign cfg_ready_o   = 1'b1;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign first_frame_o = ffr_q;
  assign free_frames_o = free_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fiu_q      <= CNT_W'(MAX_FRAMES);
      info_cfg_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAMES_IN_USE: fiu_q      <= cfg_data_i;
        CFG_INFO_IN_POOL:  info_cfg_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [CNT_W-1:0]  n_v;
    logic              rsv_v;
    logic [CNT_W-1:0]  sum_v;
    logic [CNT_W-1:0]  run_v;
    logic              found_v;
    logic [FIDX_W-1:0] end_v;
    logic [FIDX_W-1:0] f_v;
    logic [CNT_W-1:0]  hd_v;
    logic [CNT_W-1:0]  nxt_v;
    logic [2:0]        nd_v;
    logic              go_v;
    logic              bad_v;
    frame_state_e      ls_v;

    state_d    = state_q;
    pool_d     = pool_q;
    info_lat_d = info_lat_q;
    free_d     = free_q;
    cnt_d      = cnt_q;
    addr_d     = addr_q;
    dw_d       = dw_q;
    rd_pend_d  = 1'b0;
    run_d      = run_q;
    head_d     = head_q;
    last_d     = last_q;
    first_d    = first_q;
    clr_init_d = clr_init_q;
    done_d     = 1'b0;
    status_d   = status_q;
    ffr_d      = ffr_q;
    we         = 1'b0;
    wdata      = rdata;
    n_v        = '0;
    rsv_v      = 1'b0;
    sum_v      = '0;
    run_v      = run_q;
    found_v    = 1'b0;
    end_v      = '0;
    f_v        = '0;
    hd_v       = '0;
    nxt_v      = '0;
    nd_v       = '0;
    go_v       = 1'b1;
    bad_v      = 1'b0;
    ls_v       = FS_FREE;

    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wdata = '0;
        if (addr_q == '0 && info_lat_q) begin
          wdata[1:0] = FS_INFO;
        end
        addr_d = addr_q + 1'b1;
        if (addr_q == WADDR_W'(WORD_DEPTH - 1)) begin
          state_d = S_IDLE;
          if (clr_init_q) begin
            done_d   = 1'b1;
            status_d = STS_OK;
            ffr_d    = '0;
          end
        end
      end

      S_IDLE: begin
        if (accept) begin
          cnt_d = frame_count_i;
          ffr_d = '0;
          case (func_e'(func_i))
            FN_ALLOC: begin
              if (frame_count_i == '0 || frame_count_i > pool_q) begin
                done_d   = 1'b1;
                status_d = STS_RANGE;
              end else begin
                state_d = S_SRCH;
                addr_d  = '0;
                run_d   = '0;
              end
            end
            FN_RELEASE: begin
              if ({1'b0, frame_index_i} >= pool_q) begin
                done_d   = 1'b1;
                status_d = STS_RANGE;
              end else begin
                head_d  = frame_index_i;
                addr_d  = frame_index_i[FIDX_W-1:2];
                first_d = 1'b1;
                state_d = S_RRD;
              end
            end
            FN_MARK: begin
              sum_v = {1'b0, frame_index_i} + frame_count_i - 1'b1;
              if (frame_count_i == '0 || {1'b0, frame_index_i} >= pool_q ||
                  frame_count_i > pool_q - {1'b0, frame_index_i}) begin
                done_d   = 1'b1;
                status_d = STS_RANGE;
              end else begin
                head_d  = frame_index_i;
                last_d  = sum_v[FIDX_W-1:0];
                addr_d  = frame_index_i[FIDX_W-1:2];
                ffr_d   = frame_index_i;
                state_d = S_MRD;
              end
            end
            FN_INIT: begin
              n_v        = (fiu_q > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : fiu_q;
              rsv_v      = info_cfg_q && (n_v != '0);
              pool_d     = n_v;
              info_lat_d = rsv_v;
              free_d     = n_v - CNT_W'(rsv_v);
              addr_d     = '0;
              clr_init_d = 1'b1;
              state_d    = S_CLEAR;
            end
            default: ;
          endcase
        end
      end

      S_SRCH: begin
        // streaming reads: word addr_q issued, word dw_q arriving
        addr_d    = addr_q + 1'b1;
        rd_pend_d = 1'b1;
        dw_d      = addr_q;
        if (rd_pend_q) begin
          for (int k = 0; k < FRAMES_PER_WORD; k++) begin
            f_v  = {dw_q, 2'(k)};
            ls_v = frame_state_e'(rdata[2*k +: 2]);
            if (!found_v && {1'b0, f_v} < pool_q) begin
              run_v = (ls_v == FS_FREE) ? run_v + 1'b1 : '0;
              if (run_v == cnt_q) begin
                found_v = 1'b1;
                end_v   = f_v;
              end
            end
          end
          run_d = run_v;
          nxt_v = {({1'b0, dw_q} + 1'b1), 2'b00};
          if (found_v) begin
            hd_v      = {1'b0, end_v} + 1'b1 - cnt_q;
            head_d    = hd_v[FIDX_W-1:0];
            last_d    = end_v;
            ffr_d     = hd_v[FIDX_W-1:0];
            addr_d    = hd_v[FIDX_W-1:2];
            rd_pend_d = 1'b0;
            state_d   = S_MRD;
          end else if (nxt_v >= pool_q || dw_q == WADDR_W'(WORD_DEPTH - 1)) begin
            done_d   = 1'b1;
            status_d = STS_NORUN;
            ffr_d    = '0;
            state_d  = S_IDLE;
          end
        end
      end

      S_MRD: state_d = S_MWR;

      S_MWR: begin
        for (int k = 0; k < FRAMES_PER_WORD; k++) begin
          f_v = {addr_q, 2'(k)};
          if (f_v inside {[head_q:last_q]}) begin
            if (frame_state_e'(rdata[2*k +: 2]) == FS_FREE) begin
              nd_v = nd_v + 1'b1;
            end
            wdata[2*k +: 2] = (f_v == head_q) ? FS_HEAD : FS_ALLOC;
          end
        end
        we     = 1'b1;
        free_d = (free_q > CNT_W'(nd_v)) ? free_q - CNT_W'(nd_v) : '0;
        if (addr_q == last_q[FIDX_W-1:2]) begin
          done_d   = 1'b1;
          status_d = STS_OK;
          state_d  = S_IDLE;
        end else begin
          addr_d  = addr_q + 1'b1;
          state_d = S_MRD;
        end
      end

      S_RRD: state_d = S_RWR;

      S_RWR: begin
        // free the head, then allocated frames until the first other state
        for (int k = 0; k < FRAMES_PER_WORD; k++) begin
          f_v  = {addr_q, 2'(k)};
          ls_v = frame_state_e'(rdata[2*k +: 2]);
          if (f_v < head_q) begin
            wdata[2*k +: 2] = ls_v;
          end else if (f_v == head_q && first_q) begin
            if (ls_v != FS_HEAD) begin
              bad_v = 1'b1;
            end
            wdata[2*k +: 2] = FS_FREE;
            nd_v            = nd_v + 1'b1;
          end else if (go_v && {1'b0, f_v} < pool_q && ls_v == FS_ALLOC) begin
            wdata[2*k +: 2] = FS_FREE;
            nd_v            = nd_v + 1'b1;
          end else begin
            go_v = 1'b0;
          end
        end
        ffr_d = '0;
        if (bad_v) begin
          done_d   = 1'b1;
          status_d = STS_NOTHEAD;
          state_d  = S_IDLE;
        end else begin
          we      = 1'b1;
          free_d  = free_q + CNT_W'(nd_v);
          first_d = 1'b0;
          if (go_v && addr_q != WADDR_W'(WORD_DEPTH - 1)) begin
            addr_d  = addr_q + 1'b1;
            state_d = S_RRD;
          end else begin
            done_d   = 1'b1;
            status_d = STS_OK;
            state_d  = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      pool_q     <= CNT_W'(MAX_FRAMES);
      info_lat_q <= 1'b1;
      free_q     <= CNT_W'(MAX_FRAMES - 1);
      addr_q     <= '0;
      rd_pend_q  <= 1'b0;
      first_q    <= 1'b0;
      clr_init_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      pool_q     <= pool_d;
      info_lat_q <= info_lat_d;
      free_q     <= free_d;
      addr_q     <= addr_d;
      rd_pend_q  <= rd_pend_d;
      first_q    <= first_d;
      clr_init_q <= clr_init_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    dw_q     <= dw_d;
    run_q    <= run_d;
    head_q   <= head_d;
    last_q   <= last_d;
    status_q <= status_d;
    ffr_q    <= ffr_d;
  end

  `CFA_ASSERT_SAME(a_free_le_pool, done_o, free_frames_o <= pool_q, "free count above pool size")
  `CFA_ASSERT_NEXT(a_busy_after_start, accept, busy || done_o, "start transfer not taken")
  `CFA_ASSERT_SAME(a_done_idle, done_o, !busy, "result while still busy")
  `CFA_ASSERT_NEXT(a_single_strobe, done_o && !accept, !done_o, "result strobe too long")

endmodule
`default_nettype wire

// ===== rtl/cfa_frame_ram.sv =====
// Single-port-write, registered-read RAM holding packed frame states
`default_nettype none
module cfa_frame_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire
